/* design/ble_advert_packet_deframer_unit_assert.svh */
// Assertion macros shared by the deframer RTL
`ifndef BLE_ADVERT_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define BLE_ADVERT_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BLE_ADF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked outside reset
`define BLE_ADF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

/* design/ble_adf_pkg.sv */
// Shared constants, types and byte-wide helper functions for the deframer
package ble_adf_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] ACCESS_ADDRESS_RESET = 32'h8E89BED6;
    localparam logic [5:0]  CHANNEL_RESET        = 6'd39;
    localparam logic [23:0] CRC_INIT_RESET       = 24'h555555;
    localparam logic [23:0] CRC_POLY             = 24'h00065B;
    localparam logic [6:0]  WHITEN_SEED          = 7'h40;
    localparam logic [7:0]  WHITEN_TAP           = 8'h88;
    localparam logic [6:0]  HEADER_BYTES         = 7'd2;
    localparam logic [6:0]  OVERHEAD_BYTES       = 7'd5;
    localparam logic [6:0]  CRC_BYTES            = 7'd3;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ACCESS_ADDRESS = 2'd0,
        REG_CHANNEL        = 2'd1,
        REG_CRC_INIT       = 2'd2
    } cfg_reg_t;

    // Deframer state
    typedef enum logic [1:0] {
        ST_HUNT   = 2'b01,
        ST_PACKET = 2'b10
    } state_t;

    typedef struct packed {
        logic [31:0] access_address;
        logic [5:0]  channel;
        logic [23:0] crc_init;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic [6:0] byte_index;
        logic       last;
        logic       crc_ok;
    } result_t;

    typedef struct packed {
        logic [7:0] mask;
        logic [6:0] lfsr;
    } whiten_t;

    // Run the whitening LFSR for eight steps, collecting the mask LSB first
    function automatic whiten_t whiten_byte(input logic [6:0] lfsr_in);
        whiten_t    res;
        logic [7:0] w;
        logic [6:0] l;
        logic [7:0] t;
        w = 8'd0;
        l = lfsr_in;
        t = 8'd0;
        for (int j = 0; j < 8; j++) begin
            w = {1'b0, w[7:1]};
            if (l[0]) begin
                w[7] = 1'b1;
                t    = {1'b0, l} ^ WHITEN_TAP;
                l    = t[7:1];
            end else begin
                l = {1'b0, l[6:1]};
            end
        end
        res.mask = w;
        res.lfsr = l;
        return res;
    endfunction

    // Advance CRC-24 over one byte, LSB first
    function automatic logic [23:0] crc_byte(input logic [23:0] crc_in,
                                             input logic [7:0]  d);
        logic [23:0] c;
        logic        top;
        c   = crc_in;
        top = 1'b0;
        for (int j = 0; j < 8; j++) begin
            top = c[23];
            c   = {c[22:0], 1'b0};
            if (top != d[j]) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [23:0] reverse24(input logic [23:0] v);
        logic [23:0] r;
        r = 24'd0;
        for (int j = 0; j < 24; j++) begin
            r[j] = v[23-j];
        end
        return r;
    endfunction

endpackage

/* design/ble_adf_cfg.sv */
// Configuration registers of the deframer
module ble_adf_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ble_adf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ble_adf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output ble_adf_pkg::cfg_t                cfg
);
    import ble_adf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ACCESS_ADDRESS: cfg_next.access_address = cfg_wr_data[31:0];
                REG_CHANNEL:        cfg_next.channel        = cfg_wr_data[5:0];
                REG_CRC_INIT:       cfg_next.crc_init       = cfg_wr_data[23:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.access_address <= ACCESS_ADDRESS_RESET;
            cfg_reg.channel        <= CHANNEL_RESET;
            cfg_reg.crc_init       <= CRC_INIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/ble_adf_deframer.sv */
// Per-bit deframer: sync search, de-whitening, CRC-24 and byte results
module ble_adf_deframer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic                 rx_bit,
    input  ble_adf_pkg::cfg_t    cfg,
    output ble_adf_pkg::result_t res
);
    import ble_adf_pkg::*;

    state_t      state_reg,  state_next;
    logic [31:0] shift_reg,  shift_next;
    logic [2:0]  bit_reg,    bit_next;
    logic [6:0]  byte_reg,   byte_next;
    logic [5:0]  len_reg,    len_next;
    logic [6:0]  whiten_reg, whiten_next;
    logic [23:0] crc_reg,    crc_next;
    logic [23:0] rx_crc_reg, rx_crc_next;

    logic [31:0] shift_in;
    logic [2:0]  bit_inc;
    logic [6:0]  byte_inc;
    logic [6:0]  len_ext;
    logic [6:0]  crc_end;
    logic [6:0]  pos;
    whiten_t     wres;
    logic [7:0]  data;

    // Byte-wide datapath terms
    assign shift_in = {rx_bit, shift_reg[31:1]};
    assign bit_inc  = bit_reg + 3'd1;
    assign byte_inc = byte_reg + 7'd1;
    assign len_ext  = {1'b0, len_reg};
    assign crc_end  = len_ext + HEADER_BYTES;
    assign pos      = byte_reg - crc_end;
    assign wres     = whiten_byte(whiten_reg);
    assign data     = shift_in[31:24] ^ wres.mask;

    always_comb begin
        state_next  = state_reg;
        shift_next  = shift_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        len_next    = len_reg;
        whiten_next = whiten_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        res         = '0;
        if (step_en) begin
            shift_next = shift_in;
            bit_next   = bit_inc;
            case (state_reg)
                ST_HUNT: begin
                    // Look for the sync word and load the packet seeds
                    if (shift_in == cfg.access_address) begin
                        state_next  = ST_PACKET;
                        bit_next    = 3'd0;
                        byte_next   = 7'd0;
                        len_next    = 6'd0;
                        whiten_next = WHITEN_SEED | {1'b0, cfg.channel};
                        crc_next    = cfg.crc_init;
                        rx_crc_next = 24'd0;
                    end
                end
                ST_PACKET: begin
                    if (bit_inc == 3'd0) begin
                        whiten_next = wres.lfsr;
                        // Header and payload feed the CRC, trailer bytes are gathered
                        if (byte_reg < crc_end) begin
                            crc_next = crc_byte(crc_reg, data);
                        end else if (pos < CRC_BYTES) begin
                            case (pos[1:0])
                                2'd0:    rx_crc_next[7:0]   = data;
                                2'd1:    rx_crc_next[15:8]  = data;
                                2'd2:    rx_crc_next[23:16] = data;
                                default: rx_crc_next        = rx_crc_reg;
                            endcase
                        end
                        byte_next = byte_inc;
                        // Take the length from the second header byte, else test for the end
                        if (byte_inc == HEADER_BYTES) begin
                            len_next = data[5:0];
                        end else if (byte_inc == len_ext + OVERHEAD_BYTES) begin
                            res.last    = 1'b1;
                            res.crc_ok  = (crc_reg == reverse24(rx_crc_next));
                            shift_next  = 32'd0;
                            state_next  = ST_HUNT;
                            byte_next   = 7'd0;
                            len_next    = 6'd0;
                            rx_crc_next = 24'd0;
                        end
                        res.valid      = 1'b1;
                        res.data_byte  = data;
                        res.byte_index = byte_reg;
                    end
                end
                default: state_next = ST_HUNT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_HUNT;
            shift_reg  <= 32'd0;
            bit_reg    <= 3'd0;
            byte_reg   <= 7'd0;
            len_reg    <= 6'd0;
            whiten_reg <= WHITEN_SEED | {1'b0, CHANNEL_RESET};
            crc_reg    <= CRC_INIT_RESET;
            rx_crc_reg <= 24'd0;
        end else begin
            state_reg  <= state_next;
            shift_reg  <= shift_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            len_reg    <= len_next;
            whiten_reg <= whiten_next;
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
        end
    end

endmodule

/* design/ble_advert_packet_deframer_unit.sv */
// BLE advertising packet deframer, top level
//
// Input channel (s_): one demodulated bit per transfer, first bit on air first.
// The bits are searched for the configured access address; once it is seen,
// every following byte is de-whitened and issued on the result channel (m_)
// with its index in the packet. The final CRC byte carries m_last and m_crc_ok.
// Throughput: one bit per cycle while the result channel is not stalled. A bit
// taken is held in the input register until the pipeline advances; its byte (if
// it ends one) then goes to the result register and is shown on m_.
// Only every eighth bit inside a packet gives a result; others give none.
// When the receiver stalls, the result register holds and the input register
// keeps one more bit; s_ready drops only while both are full and m_ready low.
// Reset (synchronous, aresetn low) restores the register defaults, empties
// both registers and returns to the address search; no clearing pass follows.
// The cfg_ port writes registers; the user must use it between packets (not
// enforced). Channel and crc_init are sampled when the access address is found.
module ble_advert_packet_deframer_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_rx_bit,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_data_byte,
    output logic [6:0]                         m_byte_index,
    output logic                               m_last,
    output logic                               m_crc_ok,
    input  logic                               cfg_wr_en,
    input  logic [ble_adf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ble_adf_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import ble_adf_pkg::*;

    `include "ble_advert_packet_deframer_unit_assert.svh"

    cfg_t    cfg;
    result_t res;

    logic    in_valid_reg, in_valid_next;
    logic    in_bit_reg,   in_bit_next;
    result_t out_reg,      out_next;
    logic    advance;
    logic    step_en;

    ble_adf_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    ble_adf_deframer u_deframer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .rx_bit  (in_bit_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Pipeline moves when the result register is empty or being drained
    assign advance = !out_reg.valid || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Input register: load on transfer, empty once processed
    always_comb begin
        in_valid_next = in_valid_reg;
        in_bit_next   = in_bit_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_bit_next   = s_rx_bit;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Result register: hold while stalled
    always_comb begin
        out_next = out_reg;
        if (advance) begin
            out_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_reg      <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_bit_reg <= in_bit_next;
    end

    assign m_valid      = out_reg.valid;
    assign m_data_byte  = out_reg.data_byte;
    assign m_byte_index = out_reg.byte_index;
    assign m_last       = out_reg.last;
    assign m_crc_ok     = out_reg.crc_ok;

    // CRC verdict only on the closing byte
    `BLE_ADF_ASSERT_NOW(a_crc_ok_only_last, aclk, aresetn, m_valid && !m_last, !m_crc_ok)
    // A packet has at least five and at most sixty-eight bytes
    `BLE_ADF_ASSERT_NOW(a_last_index_range, aclk, aresetn, m_valid && m_last,
                        m_byte_index >= 7'd4 && m_byte_index <= 7'd67)
    // Input side stalls only behind a stalled result
    `BLE_ADF_ASSERT_NOW(a_ready_only_on_stall, aclk, aresetn, !s_ready, m_valid && !m_ready)
    // A waiting bit is not lost while the output is stalled
    `BLE_ADF_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)

endmodule

/* test/tb_ble_advert_packet_deframer_unit.sv */
// Self-checking testbench for the BLE advertising packet deframer: framed bit streams in, byte results checked
module tb_ble_advert_packet_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ble_adf_pkg::*;

    // Index past the end of the register list; writes to it must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BITS    = 60;
    localparam int NUM_PHASES    = 5;

    typedef struct packed {
        logic [7:0] data;
        logic [6:0] idx;
        logic       is_last;
        logic       ok;
    } rx_byte_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] idx;
    } end_mark_t;

    typedef struct packed {
        logic [7:0]  pre_len;
        logic        sync_ok;
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        logic [7:0]  fill;
        logic [23:0] crc_flip;
        logic        exp_ok;
        logic [6:0]  exp_last;
    } frame_row_t;

    // Directed frames: header and body extremes, shortest and longest PDU,
    // broken sync words and a corrupted CRC in each of its three bytes
    frame_row_t directed_rows [10] = '{
        '{8'd7,  1'b0, 8'h00, 8'h00, 8'h00, 24'h000000, 1'b0, 7'd0},
        '{8'd7,  1'b1, 8'h00, 8'h00, 8'h00, 24'h000000, 1'b1, 7'd4},
        '{8'd1,  1'b1, 8'hFF, 8'hFF, 8'hFF, 24'h000000, 1'b1, 7'd67},
        '{8'd9,  1'b1, 8'h02, 8'h05, 8'h00, 24'h000001, 1'b0, 7'd9},
        '{8'd3,  1'b1, 8'h40, 8'h06, 8'hA5, 24'h000100, 1'b0, 7'd10},
        '{8'd5,  1'b1, 8'h46, 8'h03, 8'h5A, 24'h800000, 1'b0, 7'd7},
        '{8'd11, 1'b1, 8'h42, 8'h0C, 8'h3C, 24'h000000, 1'b1, 7'd16},
        '{8'd1,  1'b1, 8'hFF, 8'hC0, 8'h00, 24'h000000, 1'b1, 7'd4},
        '{8'd3,  1'b0, 8'h00, 8'h00, 8'h00, 24'h000000, 1'b0, 7'd0},
        '{8'd15, 1'b1, 8'h20, 8'h01, 8'h80, 24'hFFFFFF, 1'b0, 7'd5}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_rx_bit = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic [7:0]            m_data_byte;
    logic [6:0]            m_byte_index;
    logic                  m_last;
    logic                  m_crc_ok;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Register copies shared by the frame builder and the deframing predictor
    logic [31:0] conf_aa       = ACCESS_ADDRESS_RESET;
    logic [5:0]  conf_chan     = CHANNEL_RESET;
    logic [23:0] conf_crc_init = CRC_INIT_RESET;

    // Predicted deframer state
    logic [31:0] hunt_window = '0;
    logic [2:0]  bit_phase   = '0;
    logic [6:0]  byte_pos    = '0;
    logic [5:0]  pdu_len     = '0;
    logic        in_pdu      = 1'b0;
    logic [6:0]  white_lfsr  = WHITEN_SEED | {1'b0, CHANNEL_RESET};
    logic [23:0] crc_acc     = CRC_INIT_RESET;
    logic [23:0] crc_rx      = '0;

    rx_byte_t  pending_bytes [$];
    end_mark_t packet_ends [$];
    logic      air_bits [$];

    int errors        = 0;
    int bits_sent     = 0;
    int bytes_checked = 0;
    int crc_good      = 0;
    int crc_bad       = 0;
    int frames_built  = 0;
    int settings_used = 1;
    int burst_left    = 0;
    int ready_mode    = 0;
    int ready_tick    = 0;
    int quiet         = 0;

    ble_advert_packet_deframer_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_bit     (s_rx_bit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last),
        .m_crc_ok     (m_crc_ok),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    // Eight whitening steps: mask in the upper byte, next LFSR state below
    function automatic logic [14:0] whiten_advance(input logic [6:0] lfsr);
        logic [7:0] mask;
        logic [7:0] t;
        logic [6:0] l;
        l = lfsr;
        mask = '0;
        for (int j = 0; j < 8; j++) begin
            mask[j] = l[0];
            t = {1'b0, l} ^ (l[0] ? WHITEN_TAP : 8'h00);
            l = t[7:1];
        end
        return {mask, l};
    endfunction

    // CRC-24 over one byte, least significant bit first
    function automatic logic [23:0] crc_advance(input logic [23:0] crc, input logic [7:0] d);
        logic [23:0] c;
        logic        fb;
        c = crc;
        for (int j = 0; j < 8; j++) begin
            fb = c[23] ^ d[j];
            c = {c[22:0], 1'b0} ^ (fb ? CRC_POLY : 24'h0);
        end
        return c;
    endfunction

    function automatic logic [23:0] flip24(input logic [23:0] v);
        logic [23:0] r;
        r = {<<{v}};
        return r;
    endfunction

    // Advance the predictor by one received bit and queue any byte it completes
    function automatic void deframe_bit(input logic b);
        logic [14:0] wa;
        logic [7:0]  d;
        logic [6:0]  k;
        int          pos;
        rx_byte_t    r;
        hunt_window = {b, hunt_window[31:1]};
        bit_phase = bit_phase + 3'd1;
        if (!in_pdu) begin
            // hunt: restart whitening and CRC from the registers on sync
            if (hunt_window == conf_aa) begin
                in_pdu     = 1'b1;
                bit_phase  = '0;
                byte_pos   = '0;
                pdu_len    = '0;
                white_lfsr = WHITEN_SEED | {1'b0, conf_chan};
                crc_acc    = conf_crc_init;
                crc_rx     = '0;
            end
            return;
        end
        if (bit_phase != 3'd0) begin
            return;
        end
        k = byte_pos;
        wa = whiten_advance(white_lfsr);
        white_lfsr = wa[6:0];
        d = hunt_window[31:24] ^ wa[14:7];
        pos = int'(k) - (int'(pdu_len) + 2);
        if (pos < 0) begin
            crc_acc = crc_advance(crc_acc, d);
        end else if (pos < 3) begin
            crc_rx = crc_rx | (24'(d) << (8 * pos));
        end
        byte_pos = byte_pos + 7'd1;
        r = '{data: d, idx: k, is_last: 1'b0, ok: 1'b0};
        if (byte_pos == 7'd2) begin
            pdu_len = d[5:0];
        end else if (int'(byte_pos) == int'(pdu_len) + 5) begin
            // end of packet: judge the CRC and go back to hunting
            r.is_last   = 1'b1;
            r.ok        = (crc_acc == flip24(crc_rx));
            hunt_window = '0;
            in_pdu      = 1'b0;
            byte_pos    = '0;
            pdu_len     = '0;
            crc_rx      = '0;
        end
        pending_bytes.push_back(r);
    endfunction

    // Build preamble, sync word, whitened PDU and CRC as a bit stream on air_bits
    task automatic frame_packet(input int pre_len, input logic sync_ok,
                                input logic [7:0] hdr0, input logic [7:0] hdr1,
                                input logic rand_body, input logic [7:0] fill,
                                input logic [23:0] crc_flip);
        logic [31:0] aa;
        logic [6:0]  lfsr;
        logic [23:0] crc;
        logic [23:0] rxc;
        logic [14:0] wa;
        logic [7:0]  d;
        logic [7:0]  pdu [$];
        aa = conf_aa;
        if (!sync_ok) begin
            aa = aa ^ (32'd1 << $urandom_range(0, 31));
        end
        // alternate the preamble so that it starts and ends opposite the sync LSB
        for (int i = 0; i < pre_len; i++) begin
            air_bits.push_back(~conf_aa[0] ^ i[0]);
        end
        for (int i = 0; i < 32; i++) begin
            air_bits.push_back(aa[i]);
        end
        pdu.push_back(hdr0);
        pdu.push_back(hdr1);
        for (int i = 0; i < int'(hdr1[5:0]); i++) begin
            pdu.push_back(rand_body ? 8'($urandom) : (fill ^ 8'(i)));
        end
        crc = conf_crc_init;
        foreach (pdu[i]) begin
            crc = crc_advance(crc, pdu[i]);
        end
        rxc = flip24(crc) ^ crc_flip;
        pdu.push_back(rxc[7:0]);
        pdu.push_back(rxc[15:8]);
        pdu.push_back(rxc[23:16]);
        lfsr = WHITEN_SEED | {1'b0, conf_chan};
        foreach (pdu[i]) begin
            wa = whiten_advance(lfsr);
            lfsr = wa[6:0];
            d = pdu[i] ^ wa[14:7];
            for (int j = 0; j < 8; j++) begin
                air_bits.push_back(d[j]);
            end
        end
        if (sync_ok) begin
            frames_built++;
        end
    endtask

    // Offer one bit; bursts of random length separated by random gaps
    task automatic send_bit(input logic b);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        s_valid  = 1'b1;
        s_rx_bit = b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        bits_sent++;
    endtask

    task automatic transmit_air();
        while (air_bits.size() != 0) begin
            send_bit(air_bits.pop_front());
        end
    endtask

    // Hold the sender until every predicted byte has been delivered
    task automatic drain();
        s_valid = 1'b0;
        while (pending_bytes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_ACCESS_ADDRESS: conf_aa = val;
            REG_CHANNEL:        conf_chan = val[5:0];
            REG_CRC_INIT:       conf_crc_init = val[23:0];
            default: ;
        endcase
    endtask

    task automatic setup_phase(input int ph);
        logic [31:0] aa;
        logic [5:0]  ch;
        logic [23:0] ci;
        aa = $urandom;
        ch = 6'($urandom_range(0, 39));
        ci = 24'($urandom);
        case (ph)
            1: begin ch = 6'd0;  ci = 24'h000000; end
            2: begin ch = 6'd39; ci = 24'hFFFFFF; end
            3: aa = 32'h00000000;
            4: aa = 32'hFFFFFFFF;
            5: aa = ACCESS_ADDRESS_RESET;
            default: ;
        endcase
        write_reg(REG_ACCESS_ADDRESS, aa);
        write_reg(REG_CHANNEL, {26'($urandom), ch});
        write_reg(REG_CRC_INIT, {8'($urandom), ci});
        if (ph == 2 || ph == 6) begin
            write_reg(REG_SPARE, $urandom);
        end
        settings_used++;
    endtask

    // Mostly clean frames with random content, the rest broken or plain noise
    task automatic random_packet();
        int          kind;
        int          len;
        int          pre;
        logic [23:0] flip;
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
        pre  = 2 * $urandom_range(0, 8) + 1;
        flip = '0;
        if (kind < 15) begin
            flip = ($urandom_range(0, 1) == 1) ? (24'd1 << $urandom_range(0, 23))
                                               : (24'($urandom) | 24'd1);
        end
        if (kind >= 93) begin
            repeat ($urandom_range(1, 48)) air_bits.push_back(1'($urandom));
        end else begin
            frame_packet(pre, (kind < 75) || (kind >= 85), 8'($urandom),
                         {2'($urandom), 6'(len)}, 1'b1, 8'h00, flip);
            // truncate: drop part of the tail so the next frame runs into it
            if (kind >= 85) begin
                repeat ($urandom_range(1, (len + 5) * 8 - 1)) void'(air_bits.pop_back());
            end
        end
        transmit_air();
    endtask

    // Receiver stall pattern in one of four modes, chosen at random
    always @(negedge aclk) begin
        ready_tick++;
        if (ready_tick % 300 == 0) begin
            ready_mode = $urandom_range(0, 3);
        end
        case (ready_mode)
            0: m_ready = 1'b1;
            1: m_ready = ($urandom_range(0, 3) != 0);
            2: m_ready = ((ready_tick % 7) < 4);
            default: m_ready = ((ready_tick % 24) >= 14);
        endcase
    end

    // Check delivered bytes against the prediction, then absorb the input transfer
    always @(posedge aclk) begin
        rx_byte_t  want;
        end_mark_t mark;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_bytes.size() == 0) begin
                    note_error($sformatf("unexpected byte %02h at index %0d last %0b",
                                         m_data_byte, m_byte_index, m_last));
                end else begin
                    want = pending_bytes.pop_front();
                    bytes_checked++;
                    if (m_data_byte !== want.data || m_byte_index !== want.idx ||
                        m_last !== want.is_last || m_crc_ok !== want.ok) begin
                        note_error($sformatf({"byte mismatch: expected %02h idx %0d last %0b",
                                              " crc_ok %0b, got %02h idx %0d last %0b crc_ok %0b"},
                                             want.data, want.idx, want.is_last, want.ok,
                                             m_data_byte, m_byte_index, m_last, m_crc_ok));
                    end
                    if (want.is_last) begin
                        if (want.ok) begin
                            crc_good++;
                        end else begin
                            crc_bad++;
                        end
                    end
                end
                if (m_last && packet_ends.size() != 0) begin
                    mark = packet_ends.pop_front();
                    if (m_crc_ok !== mark.ok || m_byte_index !== mark.idx) begin
                        note_error($sformatf("frame end: expected idx %0d crc_ok %0b, got %0d %0b",
                                             mark.idx, mark.ok, m_byte_index, m_crc_ok));
                    end
                end
            end
            if (s_valid && s_ready) begin
                deframe_bit(s_rx_bit);
            end
        end
    end

    // Give up when neither channel has moved a transfer for too long
    initial begin
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("tb_ble_advert_packet_deframer_unit: errors");
        $finish;
    end

    initial begin
        int phase_bits;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed frames at the reset register values
        foreach (directed_rows[i]) begin
            frame_packet(int'(directed_rows[i].pre_len), directed_rows[i].sync_ok,
                         directed_rows[i].hdr0, directed_rows[i].hdr1, 1'b0,
                         directed_rows[i].fill, directed_rows[i].crc_flip);
            if (directed_rows[i].sync_ok) begin
                packet_ends.push_back('{ok: directed_rows[i].exp_ok,
                                        idx: directed_rows[i].exp_last});
            end
            transmit_air();
        end
        drain();

        // random traffic over a series of register settings
        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            setup_phase(ph);
            phase_bits = bits_sent;
            while (bits_sent - phase_bits < PHASE_BITS) begin
                random_packet();
                if ($urandom_range(0, 7) == 0) begin
                    drain();
                end
            end
            drain();
        end

        repeat (20) @(negedge aclk);
        if (packet_ends.size() != 0) begin
            note_error($sformatf("%0d directed frames never ended", packet_ends.size()));
        end
        $display("sent %0d bits in %0d framed packets over %0d register settings",
                 bits_sent, frames_built, settings_used);
        $display("checked %0d bytes; %0d packets passed CRC, %0d failed; %0d mismatches",
                 bytes_checked, crc_good, crc_bad, errors);
        if (errors == 0) begin
            $display("tb_ble_advert_packet_deframer_unit: clean");
        end else begin
            $display("tb_ble_advert_packet_deframer_unit: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/ble_adf_pkg.sv
design/ble_adf_cfg.sv
design/ble_adf_deframer.sv
design/ble_advert_packet_deframer_unit.sv
test/tb_ble_advert_packet_deframer_unit.sv
